### src/bsc_pkg.sv
// shared types and constants of the barometric compensation pipeline
package bsc_pkg;

    localparam int RAW_W     = 24;
    localparam int COEF_W    = 16;
    localparam int TEMP_W    = 19;
    localparam int PRES_W    = 32;
    localparam int DT_W      = 25;
    localparam int PROD_W    = 42;
    localparam int WIDE_W    = 40;
    localparam int SQ_W      = 36;
    localparam int T2_W      = 18;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_COLD = -19'sd1500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_SENS      = 3'd0,
        CFG_COEF_OFFSET    = 3'd1,
        CFG_COEF_SENS_TC   = 3'd2,
        CFG_COEF_OFFSET_TC = 3'd3,
        CFG_COEF_TREF      = 3'd4,
        CFG_COEF_TEMP_SENS = 3'd5,
        CFG_LOW_TEMP_CORR  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [COEF_W-1:0] coef_sens;
        logic [COEF_W-1:0] coef_offset;
        logic [COEF_W-1:0] coef_sens_tc;
        logic [COEF_W-1:0] coef_offset_tc;
        logic [COEF_W-1:0] coef_tref;
        logic [COEF_W-1:0] coef_temp_sens;
        logic              low_temp_corr;
    } t_coefs;

    // compensated terms handed from the temperature half to the pressure half
    typedef struct packed {
        logic        [RAW_W-1:0]  raw_pressure;
        logic signed [TEMP_W-1:0] temperature;
        logic signed [WIDE_W-1:0] offset;
        logic signed [WIDE_W-1:0] sens;
    } t_front;

endpackage

### src/bsc_if.sv
// stream interfaces for raw sample words and compensated result words
interface bsc_sample_if import bsc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bsc_result_if import bsc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;
    logic signed [PRES_W-1:0] pressure;

    modport source (output valid, output temperature, output pressure, input ready);
    modport sink   (input valid, input temperature, input pressure, output ready);
endinterface

### src/baro_sensor_compensation.sv
// top level of the barometric pressure and temperature compensation pipeline
// takes one raw pressure/temperature conversion word per cycle and returns the
// compensated temperature (0.01 degC) and pressure (0.01 mbar, clamped to 32
// bits); with the output ready it runs one word per clock with no bubbles.
// five stages in bsc_front form dT, its products with the calibration words,
// the first-order terms, the low-temperature squares and the second-order
// corrections; three stages in bsc_press form the 64-bit D1*SENS product as
// two partial products, divide it down, remove the offset and clamp. each
// stage holds one word and moves whenever the stage after it is empty or
// moving, so output stalls fill bubbles first and nothing is lost or repeated.
// the calibration registers are read live by the stages, so write them only
// while no word is in flight; writes to index seven are dropped. there is no
// memory and no clearing pass after reset.
module baro_sensor_compensation import bsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    // raw sample words in, compensated words out
    bsc_sample_if.sink           i_sample,
    bsc_result_if.source         o_result
);

    t_coefs r_coefs;
    logic   front_valid;
    logic   front_ready;
    t_front front_data;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_COEF_SENS:      r_coefs.coef_sens      <= i_cfg_data;
                CFG_COEF_OFFSET:    r_coefs.coef_offset    <= i_cfg_data;
                CFG_COEF_SENS_TC:   r_coefs.coef_sens_tc   <= i_cfg_data;
                CFG_COEF_OFFSET_TC: r_coefs.coef_offset_tc <= i_cfg_data;
                CFG_COEF_TREF:      r_coefs.coef_tref      <= i_cfg_data;
                CFG_COEF_TEMP_SENS: r_coefs.coef_temp_sens <= i_cfg_data;
                CFG_LOW_TEMP_CORR:  r_coefs.low_temp_corr  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // temperature, offset and sensitivity, with low-temperature correction
    bsc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coefs  (r_coefs),
        .i_sample (i_sample),
        .o_valid  (front_valid),
        .i_ready  (front_ready),
        .o_data   (front_data)
    );

    // compensated pressure
    bsc_press u_press (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (front_valid),
        .o_ready  (front_ready),
        .i_data   (front_data),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    // the pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result word valid right after reset");
`endif

endmodule

### src/bsc_front.sv
// temperature, offset and sensitivity stages with second-order correction
module bsc_front import bsc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_coefs        i_coefs,
    bsc_sample_if.sink    i_sample,
    output logic          o_valid,
    input  logic          i_ready,
    output t_front        o_data
);

    localparam int NS = 5;

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    // stage 1
    logic        [RAW_W-1:0]  r_d1_s1;
    logic signed [DT_W-1:0]   r_dt;
    logic signed [DT_W-1:0]   n_dt;
    // stage 2
    logic        [RAW_W-1:0]  r_d1_s2;
    logic signed [PROD_W-1:0] r_p6, r_p4, r_p3;
    logic signed [PROD_W-1:0] n_p6, n_p4, n_p3;
    logic signed [2*DT_W-1:0] n_dtsq;
    logic        [T2_W-1:0]   r_t2_s2;
    // stage 3
    logic        [RAW_W-1:0]  r_d1_s3;
    logic signed [TEMP_W-1:0] r_temp1, n_temp1;
    logic signed [WIDE_W-1:0] r_off1, n_off1;
    logic signed [WIDE_W-1:0] r_sens1, n_sens1;
    logic        [T2_W-1:0]   r_t2_s3;
    logic signed [PROD_W-1:0] w_q6, w_q4, w_q3;
    // stage 4
    logic        [RAW_W-1:0]  r_d1_s4;
    logic signed [TEMP_W-1:0] r_temp1_s4;
    logic signed [WIDE_W-1:0] r_off1_s4, r_sens1_s4;
    logic        [T2_W-1:0]   r_t2_s4;
    logic        [SQ_W-1:0]   r_lo2, r_vlo2;
    logic                     r_cold, r_vcold;
    logic signed [TEMP_W:0]   w_lo, w_vlo;
    logic signed [2*TEMP_W+1:0] w_lo2, w_vlo2;
    // stage 5
    t_front                   r_out, n_out;
    logic        [WIDE_W-1:0] w_five, w_seven, w_eleven, w_off2, w_sens2;

    // stage enables: a stage moves when it is empty or the next one moves
    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_sample.ready = en[0];
    assign o_valid        = r_v[NS-1];
    assign o_data         = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_sample.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // dT = D2 - C5 * 256
    assign n_dt = signed'({1'b0, i_sample.raw_temperature})
                - signed'({1'b0, i_coefs.coef_tref, 8'h00});

    // products of dT
    always_comb begin
        n_p6   = r_dt * signed'({1'b0, i_coefs.coef_temp_sens});
        n_p4   = r_dt * signed'({1'b0, i_coefs.coef_offset_tc});
        n_p3   = r_dt * signed'({1'b0, i_coefs.coef_sens_tc});
        n_dtsq = r_dt * r_dt;
    end

    // first-order terms, divisions round toward zero
    always_comb begin
        w_q6    = (r_p6 + (r_p6[PROD_W-1] ? 42'sd8388607 : 42'sd0)) >>> 23;
        w_q4    = (r_p4 + (r_p4[PROD_W-1] ? 42'sd127 : 42'sd0)) >>> 7;
        w_q3    = (r_p3 + (r_p3[PROD_W-1] ? 42'sd255 : 42'sd0)) >>> 8;
        n_temp1 = signed'(w_q6[TEMP_W-1:0]) + TEMP_REF;
        n_off1  = signed'({8'h00, i_coefs.coef_offset, 16'h0000})
                + signed'(w_q4[WIDE_W-1:0]);
        n_sens1 = signed'({9'h000, i_coefs.coef_sens, 15'h0000})
                + signed'(w_q3[WIDE_W-1:0]);
    end

    // squares of the distance below 20 and below -15 degC
    always_comb begin
        w_lo   = signed'({r_temp1[TEMP_W-1], r_temp1}) - 20'sd2000;
        w_vlo  = signed'({r_temp1[TEMP_W-1], r_temp1}) + 20'sd1500;
        w_lo2  = w_lo * w_lo;
        w_vlo2 = w_vlo * w_vlo;
    end

    // second-order corrections
    always_comb begin
        w_five   = (WIDE_W'(r_lo2) << 2) + WIDE_W'(r_lo2);
        w_seven  = (WIDE_W'(r_vlo2) << 3) - WIDE_W'(r_vlo2);
        w_eleven = (WIDE_W'(r_vlo2) << 3) + (WIDE_W'(r_vlo2) << 1) + WIDE_W'(r_vlo2);
        w_off2   = (w_five >> 1) + (r_vcold ? w_seven : '0);
        w_sens2  = (w_five >> 2) + (r_vcold ? (w_eleven >> 1) : '0);
        n_out.raw_pressure = r_d1_s4;
        if (r_cold) begin
            n_out.temperature = r_temp1_s4 - signed'({1'b0, r_t2_s4});
            n_out.offset      = r_off1_s4 - signed'(w_off2);
            n_out.sens        = r_sens1_s4 - signed'(w_sens2);
        end else begin
            n_out.temperature = r_temp1_s4;
            n_out.offset      = r_off1_s4;
            n_out.sens        = r_sens1_s4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_d1_s1 <= i_sample.raw_pressure;
            r_dt    <= n_dt;
        end
        if (en[1]) begin
            r_d1_s2 <= r_d1_s1;
            r_p6    <= n_p6;
            r_p4    <= n_p4;
            r_p3    <= n_p3;
            r_t2_s2 <= n_dtsq[T2_W+30:31];
        end
        if (en[2]) begin
            r_d1_s3 <= r_d1_s2;
            r_temp1 <= n_temp1;
            r_off1  <= n_off1;
            r_sens1 <= n_sens1;
            r_t2_s3 <= r_t2_s2;
        end
        if (en[3]) begin
            r_d1_s4    <= r_d1_s3;
            r_temp1_s4 <= r_temp1;
            r_off1_s4  <= r_off1;
            r_sens1_s4 <= r_sens1;
            r_t2_s4    <= r_t2_s3;
            r_lo2      <= w_lo2[SQ_W-1:0];
            r_vlo2     <= w_vlo2[SQ_W-1:0];
            r_cold     <= i_coefs.low_temp_corr && (r_temp1 < TEMP_REF);
            r_vcold    <= r_temp1 < TEMP_COLD;
        end
        if (en[4]) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    // words in flight change only by accepted input and delivered output
    a_front_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        ($countones(r_v) == $past($countones(r_v))
            + int'($past(i_sample.valid && i_sample.ready))
            - int'($past(o_valid && i_ready))))
        else $error("front stage occupancy mismatch");

    // no word taken while every stage is full and the output stalls
    a_front_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |-> (!(&r_v) || i_ready))
        else $error("front accepted a word while full");
`endif

endmodule

### src/bsc_press.sv
// pressure stages: split D1*SENS product, offset removal and saturation
module bsc_press import bsc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_front        i_data,
    bsc_result_if.source  o_result
);

    localparam int NS   = 3;
    localparam int HALF = WIDE_W / 2;
    localparam int PL_W = RAW_W + HALF;
    localparam int PH_W = RAW_W + HALF + 1;
    localparam int FP_W = 65;
    localparam int Q_W  = 44;
    localparam int X_W  = Q_W + 1;

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    // stage a
    logic        [PL_W-1:0]   r_pl;
    logic signed [PH_W-1:0]   r_ph;
    logic signed [WIDE_W-1:0] r_off_a, r_off_b;
    logic signed [TEMP_W-1:0] r_temp_a, r_temp_b, r_temp_c;
    // stage b
    logic signed [FP_W-1:0]   w_prod, w_q;
    logic signed [Q_W-1:0]    r_q;
    // stage c
    logic signed [X_W-1:0]    w_x, w_p;
    logic signed [PRES_W-1:0] r_pres, n_pres;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || o_result.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready              = en[0];
    assign o_result.valid       = r_v[NS-1];
    assign o_result.temperature = r_temp_c;
    assign o_result.pressure    = r_pres;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // D1*SENS / 2^21 toward zero
    always_comb begin
        w_prod = (FP_W'(r_ph) <<< HALF) + signed'(FP_W'(r_pl));
        w_q    = (w_prod + (w_prod[FP_W-1] ? 65'sd2097151 : 65'sd0)) >>> 21;
    end

    // (. - OFF) / 2^15 toward zero, then clamp to 32 bits
    always_comb begin
        w_x = signed'({r_q[Q_W-1], r_q}) - X_W'(r_off_b);
        w_p = (w_x + (w_x[X_W-1] ? 45'sd32767 : 45'sd0)) >>> 15;
        if (w_p > 45'sd2147483647) begin
            n_pres = 32'sh7fffffff;
        end else if (w_p < -45'sd2147483648) begin
            n_pres = 32'sh80000000;
        end else begin
            n_pres = w_p[PRES_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_pl     <= i_data.raw_pressure * i_data.sens[HALF-1:0];
            r_ph     <= signed'({1'b0, i_data.raw_pressure})
                      * signed'(i_data.sens[WIDE_W-1:HALF]);
            r_off_a  <= i_data.offset;
            r_temp_a <= i_data.temperature;
        end
        if (en[1]) begin
            r_q      <= w_q[Q_W-1:0];
            r_off_b  <= r_off_a;
            r_temp_b <= r_temp_a;
        end
        if (en[2]) begin
            r_pres   <= n_pres;
            r_temp_c <= r_temp_b;
        end
    end

`ifndef SYNTHESIS
    a_press_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        ($countones(r_v) == $past($countones(r_v))
            + int'($past(i_valid && o_ready))
            - int'($past(o_result.valid && o_result.ready))))
        else $error("pressure stage occupancy mismatch");

    a_press_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> (!(&r_v) || o_result.ready))
        else $error("pressure stages accepted a word while full");
`endif

endmodule
